[hdl/mme_pkg.sv]
// Shared widths, types and state codes of the modular exponentiation core.
`default_nettype none

package mme_pkg;

  localparam int unsigned OperandWidth = 32;
  localparam int unsigned CntWidth = (OperandWidth > 1) ? $clog2(OperandWidth) : 1;

  typedef logic [OperandWidth-1:0] operand_t;
  typedef logic [CntWidth-1:0]     count_t;

  localparam operand_t ModulusReset = operand_t'(23);
  localparam count_t   CntLast      = count_t'(OperandWidth - 1);

  typedef enum logic [2:0] {
    StIdle,
    StReduce,
    StSquare,
    StMult,
    StFinish
  } state_e;

  typedef struct packed {
    logic     start;
    operand_t a;
    operand_t b;
    operand_t m;
  } mm_req_t;

  typedef struct packed {
    logic     done;
    operand_t result;
  } mm_rsp_t;

endpackage

`default_nettype wire

[hdl/mme_if.sv]
// Valid/ready channel interfaces for operand and result transactions.
`default_nettype none

interface mme_in_if;
  logic              valid;
  logic              ready;
  mme_pkg::operand_t base_value;
  mme_pkg::operand_t exponent_value;

  modport source (output valid, output base_value, output exponent_value, input ready);
  modport sink   (input valid, input base_value, input exponent_value, output ready);
endinterface

interface mme_out_if;
  logic              valid;
  logic              ready;
  mme_pkg::operand_t power_mod;

  modport source (output valid, output power_mod, input ready);
  modport sink   (input valid, input power_mod, output ready);
endinterface

`default_nettype wire

[hdl/modular_exponentiation_core.sv]
// Top level: modulus register, square-and-multiply sequencer, output register.
// Each transaction reduces the base, then squares once per exponent bit and
// multiplies once per set exponent bit, all on the one serial multiplier.
// One transaction at a time; the next is taken while the previous result waits.
// Reset: asynchronous active low, modulus returns to 23, channels go idle.
`default_nettype none

module modular_exponentiation_core (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               cfg_we_i,
  input  mme_pkg::operand_t cfg_wdata_i,
  mme_in_if.sink            in_i,
  mme_out_if.source         out_o
);

  localparam int unsigned W = mme_pkg::OperandWidth;

  mme_pkg::state_e   state_q, state_d;
  mme_pkg::operand_t mod_q;
  mme_pkg::operand_t base_q, base_d;
  mme_pkg::operand_t acc_q, acc_d;
  mme_pkg::operand_t exp_q, exp_d;
  mme_pkg::count_t   ecnt_q, ecnt_d;
  logic              start_q, start_d;
  logic              out_valid_q, out_valid_d;
  mme_pkg::operand_t out_data_q, out_data_d;

  mme_pkg::mm_req_t  mm_req;
  mme_pkg::mm_rsp_t  mm_rsp;
  mme_pkg::operand_t one_mod;
  logic              accept;
  logic              out_free;
  logic              last_bit;

  assign one_mod  = (mod_q == mme_pkg::operand_t'(1)) ? '0 : mme_pkg::operand_t'(1);
  assign accept   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign last_bit = (ecnt_q == '0);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mme_pkg::StIdle: begin
        if (accept) state_d = mme_pkg::StReduce;
      end
      mme_pkg::StReduce: begin
        if (mm_rsp.done) state_d = mme_pkg::StSquare;
      end
      mme_pkg::StSquare: begin
        if (mm_rsp.done) begin
          if (exp_q[W-1])    state_d = mme_pkg::StMult;
          else if (last_bit) state_d = mme_pkg::StFinish;
          else               state_d = mme_pkg::StSquare;
        end
      end
      mme_pkg::StMult: begin
        if (mm_rsp.done) begin
          if (last_bit) state_d = mme_pkg::StFinish;
          else          state_d = mme_pkg::StSquare;
        end
      end
      mme_pkg::StFinish: begin
        if (out_free) state_d = mme_pkg::StIdle;
      end
      default: state_d = mme_pkg::StIdle;
    endcase
  end

  // datapath and outputs
  always_comb begin
    base_d      = base_q;
    acc_d       = acc_q;
    exp_d       = exp_q;
    ecnt_d      = ecnt_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    mm_req.a    = acc_q;
    mm_req.b    = acc_q;
    mm_req.m    = mod_q;
    mm_req.start = start_q;

    if (out_valid_q && out_o.ready) out_valid_d = 1'b0;

    case (state_q)
      mme_pkg::StIdle: begin
        if (accept) begin
          base_d = in_i.base_value;
          exp_d  = in_i.exponent_value;
          ecnt_d = mme_pkg::CntLast;
        end
      end
      mme_pkg::StReduce: begin
        mm_req.a = one_mod;
        mm_req.b = base_q;
        if (mm_rsp.done) begin
          base_d = mm_rsp.result;
          acc_d  = one_mod;
        end
      end
      mme_pkg::StSquare: begin
        if (mm_rsp.done) begin
          acc_d = mm_rsp.result;
          if (!exp_q[W-1] && !last_bit) begin
            exp_d  = {exp_q[W-2:0], 1'b0};
            ecnt_d = ecnt_q - 1'b1;
          end
        end
      end
      mme_pkg::StMult: begin
        mm_req.b = base_q;
        if (mm_rsp.done) begin
          acc_d = mm_rsp.result;
          if (!last_bit) begin
            exp_d  = {exp_q[W-2:0], 1'b0};
            ecnt_d = ecnt_q - 1'b1;
          end
        end
      end
      mme_pkg::StFinish: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = (mod_q == '0) ? '0 : acc_q;
        end
      end
      default: ;
    endcase

    start_d = (accept || mm_rsp.done) &&
              (state_d == mme_pkg::StReduce || state_d == mme_pkg::StSquare ||
               state_d == mme_pkg::StMult);
  end

  mme_mulmod u_mulmod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mm_req),
    .rsp_o  (mm_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mme_pkg::StIdle;
      mod_q       <= mme_pkg::ModulusReset;
      ecnt_q      <= '0;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ecnt_q      <= ecnt_d;
      start_q     <= start_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) mod_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q     <= base_d;
    acc_q      <= acc_d;
    exp_q      <= exp_d;
    out_data_q <= out_data_d;
  end

  assign in_i.ready      = (state_q == mme_pkg::StIdle);
  assign out_o.valid     = out_valid_q;
  assign out_o.power_mod = out_data_q;

endmodule

`default_nettype wire

[hdl/mme_mulmod.sv]
// Bit-serial shift-and-add modular multiplier, one multiplier bit per cycle.
`default_nettype none

module mme_mulmod (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  mme_pkg::mm_req_t req_i,
  output mme_pkg::mm_rsp_t rsp_o
);

  localparam int unsigned W = mme_pkg::OperandWidth;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  mme_pkg::count_t   cnt_q, cnt_d;
  mme_pkg::operand_t r_q, r_d;
  mme_pkg::operand_t bsh_q, bsh_d;

  logic [W+1:0]      sum;
  logic [W+1:0]      diff1;
  logic [W+1:0]      diff2;
  logic [W+1:0]      m_ext;
  logic [W+1:0]      twice_m;
  mme_pkg::operand_t step;

  // 2r + bit*a < 3m, so at most two subtractions of m
  always_comb begin
    m_ext   = {2'b00, req_i.m};
    twice_m = {1'b0, req_i.m, 1'b0};
    sum     = {1'b0, r_q, 1'b0} + (bsh_q[W-1] ? {2'b00, req_i.a} : {(W+2){1'b0}});
    diff1   = sum - m_ext;
    diff2   = sum - twice_m;
    if (sum >= twice_m) begin
      step = diff2[W-1:0];
    end else if (sum >= m_ext) begin
      step = diff1[W-1:0];
    end else begin
      step = sum[W-1:0];
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    r_d    = r_q;
    bsh_d  = bsh_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = mme_pkg::CntLast;
      r_d    = '0;
      bsh_d  = req_i.b;
    end else if (busy_q) begin
      r_d   = step;
      bsh_d = {bsh_q[W-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q   <= r_d;
    bsh_q <= bsh_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = r_q;

endmodule

`default_nettype wire
